// ----- hw/rtl/bqd_pkg.sv -----
// Shared constants, register codes and types for the biquad DAC filter.
`timescale 1ns / 1ps
`default_nettype none

package bqd_pkg;

   localparam int SAMPLE_BITS_DEF = 12;

   localparam int COEF_W     = 32;
   localparam int OFFSET_W   = 20;
   localparam int OFFSET_FRAC = 8;
   localparam int Y_W        = 33;
   localparam int DAC_W      = 12;
   localparam int DAC_FRAC   = 16;
   localparam int RND_W      = DAC_W + DAC_FRAC;
   localparam int V_W        = Y_W + 2;
   localparam int FF_SHIFT   = 12;
   localparam int FB_SHIFT   = 28;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B1       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B2       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_OFFSET = 3'd5;

   // defaults: 100 Hz notch, Q 5, 10 kHz sampling
   localparam logic [COEF_W-1:0]   RST_COEF_B0 = 32'sd266760454;
   localparam logic [COEF_W-1:0]   RST_COEF_B1 = -32'sd532468125;
   localparam logic [COEF_W-1:0]   RST_COEF_B2 = 32'sd266760454;
   localparam logic [COEF_W-1:0]   RST_COEF_A1 = -32'sd532468125;
   localparam logic [COEF_W-1:0]   RST_COEF_A2 = 32'sd265085452;
   localparam logic [OFFSET_W-1:0] RST_OFFSET  = 20'd157286;

   localparam logic [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
   localparam logic [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

   localparam logic [RND_W-1:0] DAC_TOP  = {{DAC_W{1'b1}}, {DAC_FRAC{1'b0}}};
   localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (DAC_FRAC - 1);

   typedef struct packed {
      logic [COEF_W-1:0]   b0;
      logic [COEF_W-1:0]   b1;
      logic [COEF_W-1:0]   b2;
      logic [COEF_W-1:0]   a1;
      logic [COEF_W-1:0]   a2;
      logic [OFFSET_W-1:0] offset;
   } coef_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bqd_if.sv -----
// Channel interfaces: sample requests, DAC responses and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface bqd_req_if #(parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bqd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bqd_pkg::DAC_W-1:0]  dac_value;
   modport source (output valid, output dac_value, input ready);
   modport sink   (input valid, input dac_value, output ready);
endinterface

interface bqd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bqd_pkg::CSR_IDX_W-1:0]   index;
   logic [bqd_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bqd_csr.sv -----
// Coefficient and offset register file for the biquad DAC filter.
`timescale 1ns / 1ps
`default_nettype none

module bqd_csr (
   input  logic              clock,
   input  logic              reset,
   bqd_csr_if.sink           csr_ch,
   output bqd_pkg::coef_type coef_o
);
   import bqd_pkg::*;

   coef_type coef_ff;
   coef_type coef_in;

   assign csr_ch.ready = 1'b1;
   assign coef_o       = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_COEF_B0:       coef_in.b0     = csr_ch.data[COEF_W-1:0];
            CSR_COEF_B1:       coef_in.b1     = csr_ch.data[COEF_W-1:0];
            CSR_COEF_B2:       coef_in.b2     = csr_ch.data[COEF_W-1:0];
            CSR_COEF_A1:       coef_in.a1     = csr_ch.data[COEF_W-1:0];
            CSR_COEF_A2:       coef_in.a2     = csr_ch.data[COEF_W-1:0];
            CSR_OUTPUT_OFFSET: coef_in.offset = csr_ch.data[OFFSET_W-1:0];
            default:           coef_in        = coef_ff;   // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0     <= RST_COEF_B0;
         coef_ff.b1     <= RST_COEF_B1;
         coef_ff.b2     <= RST_COEF_B2;
         coef_ff.a1     <= RST_COEF_A1;
         coef_ff.a2     <= RST_COEF_A2;
         coef_ff.offset <= RST_OFFSET;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bqd_arith.sv -----
// One biquad step: five products, sum, saturation, offset, clamp and rounding.
`timescale 1ns / 1ps
`default_nettype none

module bqd_arith #(
   parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF
) (
   input  bqd_pkg::coef_type                coef_i,
   input  logic [SAMPLE_BITS-1:0]           x_i,
   input  logic [SAMPLE_BITS-1:0]           x1_i,
   input  logic [SAMPLE_BITS-1:0]           x2_i,
   input  logic signed [bqd_pkg::Y_W-1:0]   y1_i,
   input  logic signed [bqd_pkg::Y_W-1:0]   y2_i,
   output logic signed [bqd_pkg::Y_W-1:0]   y_o,
   output logic [bqd_pkg::DAC_W-1:0]        dac_o
);
   import bqd_pkg::*;

   localparam int FF_PW = COEF_W + SAMPLE_BITS + 1;
   localparam int FB_PW = COEF_W + Y_W;
   localparam int FF_TW = FF_PW - FF_SHIFT;
   localparam int FB_TW = FB_PW - FB_SHIFT;
   localparam int SUM_W = ((FF_TW > FB_TW) ? FF_TW : FB_TW) + 3;

   logic signed [FF_PW-1:0] p_b0;
   logic signed [FF_PW-1:0] p_b1;
   logic signed [FF_PW-1:0] p_b2;
   logic signed [FB_PW-1:0] p_a1;
   logic signed [FB_PW-1:0] p_a2;
   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-Y_W:0]      sum_hi;
   logic                    sum_fits;
   logic [V_W-1:0]          v;
   logic [RND_W-1:0]        v_clamp;
   logic [RND_W-1:0]        v_round;

   // samples are unsigned: zero-extend before the signed multiply
   assign p_b0 = $signed(coef_i.b0) * $signed({1'b0, x_i});
   assign p_b1 = $signed(coef_i.b1) * $signed({1'b0, x1_i});
   assign p_b2 = $signed(coef_i.b2) * $signed({1'b0, x2_i});
   assign p_a1 = $signed(coef_i.a1) * y1_i;
   assign p_a2 = $signed(coef_i.a2) * y2_i;

   // dropping low bits of a two's complement product is a floor shift
   assign sum = SUM_W'($signed(p_b0[FF_PW-1:FF_SHIFT]))
              + SUM_W'($signed(p_b1[FF_PW-1:FF_SHIFT]))
              + SUM_W'($signed(p_b2[FF_PW-1:FF_SHIFT]))
              - SUM_W'($signed(p_a1[FB_PW-1:FB_SHIFT]))
              - SUM_W'($signed(p_a2[FB_PW-1:FB_SHIFT]));

   // saturate to Q17.16: in range when all bits above the sign agree with it
   assign sum_hi   = sum[SUM_W-1:Y_W-1];
   assign sum_fits = (&sum_hi) | ~(|sum_hi);
   assign y_o      = sum_fits ? sum[Y_W-1:0] : (sum[SUM_W-1] ? Y_MIN : Y_MAX);

   assign v = {{(V_W-Y_W){y_o[Y_W-1]}}, y_o}
            + {{(V_W-OFFSET_W-OFFSET_FRAC){1'b0}}, coef_i.offset, {OFFSET_FRAC{1'b0}}};

   always_comb begin
      if (v[V_W-1]) begin
         v_clamp = '0;
      end else if (v[V_W-2:0] > (V_W-1)'(DAC_TOP)) begin
         v_clamp = DAC_TOP;
      end else begin
         v_clamp = v[RND_W-1:0];
      end
   end

   // round half up; the clamp keeps the sum below the carry into bit RND_W
   assign v_round = v_clamp + RND_HALF;
   assign dac_o   = v_round[RND_W-1:DAC_FRAC];

endmodule

`default_nettype wire

// ----- hw/rtl/biquad_iir_filter_to_dac.sv -----
// Top level: direct-form-I biquad from converter samples to 12-bit DAC codes.
//
//   channel | dir | beat contents              | accepted when
//   --------+-----+----------------------------+--------------------------
//   req_ch  | in  | sample [SAMPLE_BITS-1:0]   | req_ch.valid & req_ch.ready
//   rsp_ch  | out | dac_value [11:0]           | rsp_ch.valid & rsp_ch.ready
//   csr_ch  | in  | index [2:0], data [31:0]   | csr_ch.valid (ready tied high)
//
// One beat per cycle sustained while the response side does not stall. A sample
// is held in the input register, then the filter step runs combinationally
// into the result register, which offers the response. The cycle time is set
// by the feedback loop: output history -> 33x32 multiply -> five term sum ->
// saturate -> output history.
// Reset (synchronous) empties both registers, zeroes the sample and output
// history and loads the 100 Hz notch coefficients and default offset.
// A stalled response holds in the result register; one more sample waits in
// the input register, and req_ch.ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module biquad_iir_filter_to_dac #(
   parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bqd_req_if.sink    req_ch,
   bqd_rsp_if.source  rsp_ch,
   bqd_csr_if.sink    csr_ch
);
   import bqd_pkg::*;

   coef_type coef;

   // input stage
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [SAMPLE_BITS-1:0] x_ff;

   // filter history
   logic [SAMPLE_BITS-1:0] x1_ff;
   logic [SAMPLE_BITS-1:0] x2_ff;
   logic signed [Y_W-1:0]  y1_ff;
   logic signed [Y_W-1:0]  y2_ff;

   // result stage
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [DAC_W-1:0]       dac_ff;

   logic signed [Y_W-1:0]  y_new;
   logic [DAC_W-1:0]       dac_new;
   logic                   advance;

   bqd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .coef_o (coef)
   );

   bqd_arith #(.SAMPLE_BITS(SAMPLE_BITS)) u_arith (
      .coef_i (coef),
      .x_i    (x_ff),
      .x1_i   (x1_ff),
      .x2_i   (x2_ff),
      .y1_i   (y1_ff),
      .y2_i   (y2_ff),
      .y_o    (y_new),
      .dac_o  (dac_new)
   );

   // advance the held sample when the result register is free or draining
   assign advance      = in_valid_ff & (~out_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~in_valid_ff | advance;

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.dac_value = dac_ff;

   always_comb begin
      in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;
      out_valid_in = advance ? 1'b1 : (out_valid_ff & ~rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // shift the history only when the step's result is taken in
         if (advance) begin
            x1_ff <= x_ff;
            x2_ff <= x1_ff;
            y1_ff <= y_new;
            y2_ff <= y1_ff;
         end
      end
   end

   // payload registers: load with their stage, no reset
   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         x_ff <= req_ch.sample;
      end
      if (advance) begin
         dac_ff <= dac_new;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bqd_checker.sv -----
// Port-level checks for the biquad DAC filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bqd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bqd_pkg::DAC_W-1:0]  rsp_dac_value
);
   import bqd_pkg::*;

   // a stalled response beat holds its code
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dac_value))
      else $error("response beat changed while stalled");

   // no response beat right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // back pressure on requests only while a response is stuck
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a stalled response");

   // an accepted sample reaches the output if the output drains
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
      else $error("response missing after accepted request");

endmodule

bind biquad_iir_filter_to_dac bqd_checker u_bqd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_dac_value (rsp_ch.dac_value)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking bench for the biquad DAC filter: directed corners, then random streams.
`timescale 1ns / 1ps

module tb_top;
   import bqd_pkg::*;

   // Indexes past the last register; writes to them must leave every setting as it was.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int RAND_PHASES  = 9;
   localparam int PHASE_ITEMS  = 195;
   localparam int SQUEEZE_LEN  = 80;

   // Track the filter state on the side and hold the DAC codes still owed by the block.
   class dac_code_check;
      logic signed [COEF_W-1:0]   b0, b1, b2, a1, a2;
      logic [OFFSET_W-1:0]        offset;
      logic [SAMPLE_BITS_DEF-1:0] x1, x2;
      logic signed [Y_W-1:0]      y1, y2;
      logic [DAC_W-1:0]           codes_due[$];
      int                         mismatches;

      function new();
         b0 = RST_COEF_B0;
         b1 = RST_COEF_B1;
         b2 = RST_COEF_B2;
         a1 = RST_COEF_A1;
         a2 = RST_COEF_A2;
         offset = RST_OFFSET;
         x1 = '0;
         x2 = '0;
         y1 = '0;
         y2 = '0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_COEF_B0:       b0 = data;
            CSR_COEF_B1:       b1 = data;
            CSR_COEF_B2:       b2 = data;
            CSR_COEF_A1:       a1 = data;
            CSR_COEF_A2:       a2 = data;
            CSR_OUTPUT_OFFSET: offset = data[OFFSET_W-1:0];
            default: ;
         endcase
      endfunction

      // Exact product, then floor toward minus infinity by sh bits.
      function logic signed [69:0] scaled(logic signed [COEF_W-1:0] c,
                                          logic signed [33:0] d, int sh);
         logic signed [69:0] wc;
         logic signed [69:0] wd;
         wc = c;
         wd = d;
         return (wc * wd) >>> sh;
      endfunction

      function logic [DAC_W-1:0] next_dac_code(logic [SAMPLE_BITS_DEF-1:0] x);
         logic signed [69:0]    acc;
         logic signed [69:0]    v;
         logic signed [Y_W-1:0] y;
         acc = scaled(b0, $signed({22'd0, x}), FF_SHIFT)
             + scaled(b1, $signed({22'd0, x1}), FF_SHIFT)
             + scaled(b2, $signed({22'd0, x2}), FF_SHIFT)
             - scaled(a1, y1, FB_SHIFT)
             - scaled(a2, y2, FB_SHIFT);
         if (acc > $signed({37'd0, Y_MAX}))
            y = Y_MAX;
         else if (acc < $signed({{37{1'b1}}, Y_MIN}))
            y = Y_MIN;
         else
            y = acc[Y_W-1:0];
         x2 = x1;
         x1 = x;
         y2 = y1;
         y1 = y;
         v = y;
         v = v + ($signed({50'd0, offset}) <<< OFFSET_FRAC);
         if (v < 0)
            v = 0;
         else if (v > $signed({42'd0, DAC_TOP}))
            v = $signed({42'd0, DAC_TOP});
         v = v + $signed({42'd0, RND_HALF});
         return v[DAC_FRAC +: DAC_W];
      endfunction

      function void take_sample(logic [SAMPLE_BITS_DEF-1:0] x);
         codes_due.push_back(next_dac_code(x));
      endfunction

      function int pending();
         return codes_due.size();
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task check_dac(logic [DAC_W-1:0] got);
         logic [DAC_W-1:0] want;
         if (codes_due.size() == 0) begin
            report($sformatf("dac_value %0d with no sample outstanding", got));
            return;
         end
         want = codes_due.pop_front();
         if (got !== want)
            report($sformatf("dac_value %0d, want %0d", got, want));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bqd_req_if req_ch ();
   bqd_rsp_if rsp_ch ();
   bqd_csr_if csr_ch ();

   biquad_iir_filter_to_dac uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   dac_code_check sb = new();

   // Idle knobs shared by the two sides; the main sequence changes them in chosen phases.
   bit send_gaps   = 1'b1;
   bit take_stalls = 1'b1;
   int holds_asked = 0;

   always #5 clock = ~clock;

   // Offer one sample, maybe after a gap, and hold it until the block takes the beat.
   // Leave valid high afterwards so back-to-back beats need no extra edge.
   task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] s);
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_sample(s);
   endtask

   // Drop valid and wait for every owed DAC code; the block is idle after that.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // One register beat; valid stays high so the next write can follow right away.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, data);
   endtask

   // Load a full coefficient set; optionally poke the unused indexes too.
   task automatic load_coefs(input coef_type c, input bit stray);
      write_reg(CSR_COEF_B0, c.b0);
      write_reg(CSR_COEF_B1, c.b1);
      write_reg(CSR_COEF_B2, c.b2);
      write_reg(CSR_COEF_A1, c.a1);
      write_reg(CSR_COEF_A2, c.a2);
      write_reg(CSR_OUTPUT_OFFSET, {{(CSR_DATA_W-OFFSET_W){1'b0}}, c.offset});
      if (stray) begin
         write_reg(CSR_SPARE_LO, $urandom);
         write_reg(CSR_SPARE_HI, $urandom);
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Uniform value in +/- 2^span, as a Q3.28 coefficient.
   function automatic logic [COEF_W-1:0] small_coef(input int span);
      int r;
      r = $urandom_range(0, 1 << (span + 1));
      return r - (1 << span);
   endfunction

   function automatic coef_type pick_coefs();
      coef_type c;
      case ($urandom_range(0, 3))
         0: c = '{RST_COEF_B0, RST_COEF_B1, RST_COEF_B2, RST_COEF_A1, RST_COEF_A2,
                  RST_OFFSET};
         1: begin
            // stable filter: gains at most one half, poles well inside the unit circle
            c.b0 = small_coef(27);
            c.b1 = small_coef(27);
            c.b2 = small_coef(27);
            c.a1 = small_coef(26);
            c.a2 = small_coef(26);
         end
         default: begin
            c.b0 = $urandom;
            c.b1 = $urandom;
            c.b2 = $urandom;
            c.a1 = $urandom;
            c.a2 = $urandom;
         end
      endcase
      c.offset = ($urandom_range(0, 2) == 0) ? RST_OFFSET : OFFSET_W'($urandom);
      return c;
   endfunction

   task automatic run_stream(input int count);
      logic [SAMPLE_BITS_DEF-1:0] s;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0:       s = '0;
            1:       s = '1;
            default: s = $urandom_range(0, (1 << SAMPLE_BITS_DEF) - 1);
         endcase
         send_sample(s);
      end
   endtask

   // Response side: check each accepted beat, then pick ready for the next edge.
   // Stall in short random bursts, or hold off for a long stretch when asked so
   // the input register and result register both fill and req_ch.ready drops.
   initial begin : take_side
      int stall_left;
      int holds_seen;
      stall_left = 0;
      holds_seen = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_dac(rsp_ch.dac_value);
         if (holds_asked != holds_seen) begin
            holds_seen = holds_asked;
            stall_left = SQUEEZE_LEN;
         end else if (stall_left == 0 && take_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [SAMPLE_BITS_DEF-1:0] notch_walk[10] = '{
         12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0,
         12'd2048, 12'd2047, 12'd1, 12'hAAA, 12'h555
      };
      coef_type c;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = CSR_COEF_B0;
      csr_ch.data   = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Default notch straight out of reset: steps, extremes and alternating bits.
      foreach (notch_walk[i])
         send_sample(notch_walk[i]);

      // Unity gain, no offset: the code must equal the sample.
      drain();
      c = '{32'h1000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 20'd0};
      load_coefs(c, 1'b0);
      send_sample(12'd0);
      send_sample(12'd2049);
      send_sample(12'd4095);

      // Largest feedforward gains and positive feedback: drive y into the top rail
      // and keep it there on zero input through the saved history.
      drain();
      c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            20'd0};
      load_coefs(c, 1'b0);
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd0);

      // Most negative feedforward gains with full offset: bottom rail and top clamp.
      drain();
      c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            20'hFFFFF};
      load_coefs(c, 1'b0);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd0);

      // All gains zero, so the code is the rounded offset: exact halves round up,
      // just under a half rounds down.
      drain();
      c = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 20'h00080};
      load_coefs(c, 1'b0);
      send_sample(12'd4095);
      drain();
      c.offset = 20'h0017F;
      load_coefs(c, 1'b0);
      send_sample(12'd100);
      drain();
      c.offset = 20'h00180;
      load_coefs(c, 1'b1);
      send_sample(12'd7);
      send_sample(12'd4095);

      // Random streams, each under a fresh coefficient set.
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         drain();
         c = pick_coefs();
         load_coefs(c, phase % 3 == 1);
         if (phase == 2) begin
            // keep offering with no gaps while the response side holds off
            send_gaps = 1'b0;
            holds_asked++;
            run_stream(PHASE_ITEMS);
            send_gaps = 1'b1;
         end else begin
            if (phase == RAND_PHASES - 1) begin
               send_gaps   = 1'b0;
               take_stalls = 1'b0;
            end
            run_stream(PHASE_ITEMS);
         end
      end

      drain();
      // catch any stray beat after the last owed code
      repeat (6) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Stop a hung run well past the slowest legal one.
   initial begin : watchdog
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule
